// File: hdl/bvc_pkg.sv
// Shared types and constants for the balance / velocity controller.
// No dependencies; used by bvc_vel_state and balance_velocity_controller_unit.
package bvc_pkg;

  // Width of every signed result field on the result word
  localparam int FIELD_W = 16;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ZERO_ANGLE     = 3'd0,
    REG_TILT_LIMIT     = 3'd1,
    REG_TILT_P_GAIN    = 3'd2,
    REG_TILT_D_GAIN    = 3'd3,
    REG_SPEED_P_GAIN   = 3'd4,
    REG_SPEED_I_GAIN   = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6,
    REG_SPEED_TARGET   = 3'd7
  } bvc_reg_t;

  // Register reset values
  localparam logic signed [16:0] ZERO_ANGLE_RST     = -17'sd256;
  localparam logic [15:0]        TILT_LIMIT_RST     = 16'd15360;
  localparam logic [15:0]        TILT_P_GAIN_RST    = 16'd23040;
  localparam logic [15:0]        TILT_D_GAIN_RST    = 16'd384;
  localparam logic [15:0]        SPEED_P_GAIN_RST   = 16'd5120;
  localparam logic [15:0]        SPEED_I_GAIN_RST   = 16'd0;
  localparam logic [15:0]        INTEGRAL_LIMIT_RST = 16'd1000;
  localparam logic signed [16:0] SPEED_TARGET_RST   = 17'sd0;

  // One input sample
  typedef struct packed {
    logic signed [16:0] tilt_angle;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
  } sample_t;

  // One result word
  typedef struct packed {
    logic signed [15:0] motor_drive;
    logic signed [15:0] balance_term;
    logic signed [15:0] velocity_term;
    logic               tilt_fault;
  } result_t;

  // Control from the pipeline to the velocity state block
  typedef struct packed {
    logic update;   // a sample moves into the second stage
    logic fault;    // that sample is out of the tilt window
  } state_ctl_t;

endpackage

// File: hdl/bvc_vel_state.sv
// Velocity loop state: halving low-pass on the speed error and clamped integral.
// Depends on bvc_pkg (state_ctl_t).
module bvc_vel_state #(
  parameter int FRAC_BITS = 8,
  localparam int FILT_W = 20 + FRAC_BITS,
  localparam int INT_W  = 18 + FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bvc_pkg::state_ctl_t      ctl,
  input  logic signed [15:0]       left_count,
  input  logic signed [15:0]       right_count,
  input  logic signed [16:0]       speed_target,
  input  logic [15:0]              integral_limit,
  output logic signed [FILT_W-1:0] filtered_error,
  output logic signed [INT_W-1:0]  error_integral
);

  localparam int ERR_W  = 19;
  localparam int SUM_W  = FILT_W + 1;
  localparam int ISUM_W = FILT_W + 1;

  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W-1:0]  filt_sum;
  logic signed [SUM_W-1:0]  filt_half;
  logic signed [ISUM_W-1:0] integ_sum;
  logic signed [ISUM_W-1:0] ilim;
  logic signed [FILT_W-1:0] filtered_error_next;
  logic signed [INT_W-1:0]  error_integral_next;

  // Speed error, scaled to the fraction grid and halved toward zero
  always_comb begin
    err = ERR_W'(left_count) + ERR_W'(right_count) - ERR_W'(speed_target);
    filt_sum = SUM_W'(filtered_error) + (SUM_W'(err) <<< FRAC_BITS);
    if (filt_sum < 0) begin
      filt_half = (filt_sum + SUM_W'(1)) >>> 1;
    end else begin
      filt_half = filt_sum >>> 1;
    end
    filtered_error_next = filt_half[FILT_W-1:0];
  end

  // Integral with symmetric clamp; a fault clears it
  always_comb begin
    ilim = ISUM_W'({integral_limit, {FRAC_BITS{1'b0}}});
    integ_sum = ISUM_W'(error_integral) + ISUM_W'(filtered_error_next);
    if (integ_sum > ilim) begin
      integ_sum = ilim;
    end else if (integ_sum < -ilim) begin
      integ_sum = -ilim;
    end
    error_integral_next = integ_sum[INT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_error <= '0;
      error_integral <= '0;
    end else if (ctl.update) begin
      if (ctl.fault) begin
        error_integral <= '0;
      end else begin
        filtered_error <= filtered_error_next;
        error_integral <= error_integral_next;
      end
    end
  end

endmodule

// File: hdl/balance_velocity_controller_unit.sv
// Top level: balance PD plus velocity PI drive controller, four-stage pipeline.
// Depends on bvc_pkg and bvc_vel_state.
//
//   channel  | valid / ready              | payload
//   ---------+----------------------------+--------------------------------
//   sample   | sample_valid, sample_ready | sample (bvc_pkg::sample_t)
//   result   | result_valid, result_ready | result (bvc_pkg::result_t)
//   cfg      | cfg_valid, cfg_ready       | cfg_index (3 b), cfg_data (17 b)
//
// One sample per cycle sustained while result_ready is high.
// Stages: input register, tilt check / balance multiplies / state update,
// velocity multiplies / balance sum, velocity sum and drive saturation.
// Each stage moves up when the one after it is empty or moving, so bubbles
// fill while a result waits. Reset clears valids, loop state; presets cfg regs.
// cfg_ready stays high; user must write registers with pipe empty, unchecked.
module balance_velocity_controller_unit #(
  parameter int FRAC_BITS   = 8,
  parameter int DRIVE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  bvc_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output bvc_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [16:0]      cfg_data
);

  localparam int FILT_W  = 20 + FRAC_BITS;
  localparam int INT_W   = 18 + FRAC_BITS;
  localparam int PB_W    = 35;
  localparam int PG_W    = 33;
  localparam int PV_W    = 17 + FILT_W;
  localparam int PI_W    = 17 + INT_W;
  localparam int WIDE_W  = 40 + FRAC_BITS;
  localparam int FIELD_W = bvc_pkg::FIELD_W;
  localparam logic signed [WIDE_W-1:0] DRV_MAX =
    (WIDE_W'(1) <<< (DRIVE_WIDTH - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] DRV_MIN = -DRV_MAX - WIDE_W'(1);

  // Truncating division by a power of two (rounds toward zero)
  function automatic logic signed [WIDE_W-1:0] trunc_pow2(
    input logic signed [WIDE_W-1:0] v,
    input int                       sh
  );
    logic signed [WIDE_W-1:0] bias;
    logic signed [WIDE_W-1:0] r;
    bias = (WIDE_W'(1) <<< sh) - WIDE_W'(1);
    if (v < 0) begin
      r = (v + bias) >>> sh;
    end else begin
      r = v >>> sh;
    end
    return r;
  endfunction

  // Saturate to the drive width
  function automatic logic signed [DRIVE_WIDTH-1:0] sat_drive(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [DRIVE_WIDTH-1:0] r;
    if (v > DRV_MAX) begin
      r = DRV_MAX[DRIVE_WIDTH-1:0];
    end else if (v < DRV_MIN) begin
      r = DRV_MIN[DRIVE_WIDTH-1:0];
    end else begin
      r = v[DRIVE_WIDTH-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic signed [16:0] zero_angle;
  logic [15:0]        tilt_limit;
  logic [15:0]        tilt_p_gain;
  logic [15:0]        tilt_d_gain;
  logic [15:0]        speed_p_gain;
  logic [15:0]        speed_i_gain;
  logic [15:0]        integral_limit;
  logic signed [16:0] speed_target;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_angle     <= bvc_pkg::ZERO_ANGLE_RST;
      tilt_limit     <= bvc_pkg::TILT_LIMIT_RST;
      tilt_p_gain    <= bvc_pkg::TILT_P_GAIN_RST;
      tilt_d_gain    <= bvc_pkg::TILT_D_GAIN_RST;
      speed_p_gain   <= bvc_pkg::SPEED_P_GAIN_RST;
      speed_i_gain   <= bvc_pkg::SPEED_I_GAIN_RST;
      integral_limit <= bvc_pkg::INTEGRAL_LIMIT_RST;
      speed_target   <= bvc_pkg::SPEED_TARGET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bvc_pkg::REG_ZERO_ANGLE:     zero_angle     <= cfg_data;
        bvc_pkg::REG_TILT_LIMIT:     tilt_limit     <= cfg_data[15:0];
        bvc_pkg::REG_TILT_P_GAIN:    tilt_p_gain    <= cfg_data[15:0];
        bvc_pkg::REG_TILT_D_GAIN:    tilt_d_gain    <= cfg_data[15:0];
        bvc_pkg::REG_SPEED_P_GAIN:   speed_p_gain   <= cfg_data[15:0];
        bvc_pkg::REG_SPEED_I_GAIN:   speed_i_gain   <= cfg_data[15:0];
        bvc_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[15:0];
        bvc_pkg::REG_SPEED_TARGET:   speed_target   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline valids and stage handshakes
  logic v1, v2, v3;
  logic ld2, ld3, ld4;
  logic free2, free3;

  always_comb begin
    ld4          = v3 && (!result_valid || result_ready);
    free3        = !v3 || ld4;
    ld3          = v2 && free3;
    free2        = !v2 || ld3;
    ld2          = v1 && free2;
    sample_ready = !v1 || ld2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (sample_ready) v1 <= sample_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (!result_valid || result_ready) result_valid <= v3;
    end
  end

  // Stage 1: input word
  bvc_pkg::sample_t s1;

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      s1 <= sample;
    end
  end

  // Stage 2: tilt window, balance products, loop state update
  logic signed [17:0]      lim_s;
  logic signed [17:0]      bias;
  logic                    fault1;
  logic signed [PB_W-1:0]  pbal_next;
  logic signed [PG_W-1:0]  pgyr_next;
  logic                    fault2;
  logic signed [PB_W-1:0]  pbal2;
  logic signed [PG_W-1:0]  pgyr2;

  always_comb begin
    lim_s     = $signed({2'b00, tilt_limit});
    fault1    = (18'(s1.tilt_angle) < -lim_s) || (18'(s1.tilt_angle) > lim_s);
    bias      = 18'(s1.tilt_angle) - 18'(zero_angle);
    pbal_next = $signed({1'b0, tilt_p_gain}) * bias;
    pgyr_next = $signed({1'b0, tilt_d_gain}) * s1.gyro_rate;
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      fault2 <= fault1;
      pbal2  <= pbal_next;
      pgyr2  <= pgyr_next;
    end
  end

  bvc_pkg::state_ctl_t     st_ctl;
  logic signed [FILT_W-1:0] filtered_error;
  logic signed [INT_W-1:0]  error_integral;

  assign st_ctl.update = ld2;
  assign st_ctl.fault  = fault1;

  bvc_vel_state #(
    .FRAC_BITS(FRAC_BITS)
  ) u_vel_state (
    .clk            (clk),
    .rst            (rst),
    .ctl            (st_ctl),
    .left_count     (s1.left_count),
    .right_count    (s1.right_count),
    .speed_target   (speed_target),
    .integral_limit (integral_limit),
    .filtered_error (filtered_error),
    .error_integral (error_integral)
  );

  // Stage 3: velocity products, balance term
  logic signed [WIDE_W-1:0]      bal_sum;
  logic signed [DRIVE_WIDTH-1:0] bal_next;
  logic signed [PV_W-1:0]        pvkp_next;
  logic signed [PI_W-1:0]        pvki_next;
  logic                          fault3;
  logic signed [DRIVE_WIDTH-1:0] bal3;
  logic signed [PV_W-1:0]        pvkp3;
  logic signed [PI_W-1:0]        pvki3;

  always_comb begin
    bal_sum   = trunc_pow2(WIDE_W'(pbal2), 2 * FRAC_BITS)
              + trunc_pow2(WIDE_W'(pgyr2), FRAC_BITS);
    bal_next  = sat_drive(-bal_sum);
    pvkp_next = $signed({1'b0, speed_p_gain}) * filtered_error;
    pvki_next = $signed({1'b0, speed_i_gain}) * error_integral;
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      fault3 <= fault2;
      bal3   <= bal_next;
      pvkp3  <= pvkp_next;
      pvki3  <= pvki_next;
    end
  end

  // Stage 4: velocity term, combined drive, result register
  logic signed [WIDE_W-1:0]      vel_sum;
  logic signed [DRIVE_WIDTH-1:0] vel;
  logic signed [DRIVE_WIDTH-1:0] drive;
  logic signed [WIDE_W-1:0]      bal_ext;
  logic signed [WIDE_W-1:0]      vel_ext;
  logic signed [WIDE_W-1:0]      drive_ext;
  bvc_pkg::result_t              result_next;

  always_comb begin
    vel_sum   = trunc_pow2(WIDE_W'(pvkp3), 2 * FRAC_BITS)
              + trunc_pow2(WIDE_W'(pvki3), 2 * FRAC_BITS);
    vel       = sat_drive(vel_sum);
    drive     = sat_drive(WIDE_W'(bal3) + WIDE_W'(vel));
    bal_ext   = WIDE_W'(bal3);
    vel_ext   = WIDE_W'(vel);
    drive_ext = WIDE_W'(drive);
    if (fault3) begin
      result_next.motor_drive   = '0;
      result_next.balance_term  = '0;
      result_next.velocity_term = '0;
      result_next.tilt_fault    = 1'b1;
    end else begin
      result_next.motor_drive   = drive_ext[FIELD_W-1:0];
      result_next.balance_term  = bal_ext[FIELD_W-1:0];
      result_next.velocity_term = vel_ext[FIELD_W-1:0];
      result_next.tilt_fault    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      result <= result_next;
    end
  end

endmodule
